@@ rtl/rfft_pkg.sv @@
// Shared types and constants of the radial fog factor table core.
// No dependencies; every other file takes names from here by scope.
package rfft_pkg;

    // Default cell count per axis
    localparam int unsigned MAX_STEPS_DEF = 256;

    // Exponent limit 12.0 in Q.16; beyond it the factor is zero
    localparam logic [20:0] T_LIMIT = 21'hC0000;

    // Fog modes
    localparam logic [1:0] MODE_LIN = 2'd0;
    localparam logic [1:0] MODE_EXP = 2'd1;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_NEAR  = 3'd1;
    localparam logic [2:0] CFG_FAR   = 3'd2;
    localparam logic [2:0] CFG_DENS  = 3'd3;
    localparam logic [2:0] CFG_STEP  = 3'd4;
    localparam logic [2:0] CFG_STEPS = 3'd5;

    // Reset values of the registers
    localparam logic [23:0] FAR_RST   = 24'hFFFFFF;
    localparam logic [15:0] DENS_RST  = 16'd256;
    localparam logic [15:0] STEP_RST  = 16'd256;
    localparam logic [8:0]  STEPS_RST = 9'd256;

    // How the factor of a cell is found
    typedef enum logic [1:0] {
        CLS_ONE,
        CLS_ZERO,
        CLS_LIN,
        CLS_EXP
    } t_cls;

    typedef struct packed {
        logic [7:0] cell_x;
        logic [7:0] cell_z;
    } t_in_req;

    typedef struct packed {
        logic [7:0] fog_byte;
        logic       cell_valid;
    } t_out_req;

    // Distance unit to divider unit
    typedef struct packed {
        logic        ok;
        logic [24:0] rad;
    } t_dist_req;

    // Divider unit to exponential unit
    typedef struct packed {
        logic        ok;
        t_cls        cls;
        logic        exp2;
        logic [20:0] q;
    } t_fac_req;

endpackage

@@ rtl/radial_fog_factor_table_core.sv @@
// Top level of the radial fog factor table core: configuration registers,
// pipeline advance control and output register. Uses rfft_pkg, rfft_dist,
// rfft_div and rfft_exp.
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_stall    i_req  (cell_x, cell_z)
//  result    out        o_valid / i_stall    o_req  (fog_byte, cell_valid)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request per cycle is taken while the pipeline advances. The pipeline holds the
// 25-stage square root, 21-stage divider and 42-stage series.
// Reset is synchronous, clears valid bits and sets configuration registers to defaults.
// A held result freezes the pipeline only when its last stage holds a request;
// bubbles keep draining, so requests are taken while a result waits.
module radial_fog_factor_table_core #(
    parameter int unsigned MAX_STEPS = rfft_pkg::MAX_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rfft_pkg::t_in_req   i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output rfft_pkg::t_out_req  o_req,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);
    logic [1:0]  r_fog_mode;
    logic [23:0] r_near, r_far;
    logic [15:0] r_density, r_step;
    logic [8:0]  r_steps;

    logic                 w_out_free, w_adv;
    logic                 w_dv, w_fv, w_last_valid;
    rfft_pkg::t_dist_req  w_dist;
    rfft_pkg::t_fac_req   w_fac;
    rfft_pkg::t_out_req   w_last;

    logic                 r_out_valid;
    rfft_pkg::t_out_req   r_out;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fog_mode <= rfft_pkg::MODE_LIN;
            r_near     <= '0;
            r_far      <= rfft_pkg::FAR_RST;
            r_density  <= rfft_pkg::DENS_RST;
            r_step     <= rfft_pkg::STEP_RST;
            r_steps    <= rfft_pkg::STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfft_pkg::CFG_MODE:  r_fog_mode <= i_cfg_data[1:0];
                rfft_pkg::CFG_NEAR:  r_near     <= i_cfg_data;
                rfft_pkg::CFG_FAR:   r_far      <= i_cfg_data;
                rfft_pkg::CFG_DENS:  r_density  <= i_cfg_data[15:0];
                rfft_pkg::CFG_STEP:  r_step     <= i_cfg_data[15:0];
                rfft_pkg::CFG_STEPS: r_steps    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Advance whenever the output can take the last stage or it is empty
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = w_out_free || !w_last_valid;
    assign o_stall    = !w_adv;

    rfft_dist #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (i_valid),
        .i_req          (i_req),
        .i_step_length  (r_step),
        .i_steps_in_use (r_steps),
        .o_valid        (w_dv),
        .o_dist         (w_dist)
    );

    rfft_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (w_dv),
        .i_dist     (w_dist),
        .i_fog_mode (r_fog_mode),
        .i_near     (r_near),
        .i_far      (r_far),
        .i_density  (r_density),
        .o_valid    (w_fv),
        .o_fac      (w_fac)
    );

    rfft_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_fv),
        .i_fac   (w_fac),
        .o_valid (w_last_valid),
        .o_req   (w_last)
    );

    // Output register: load from the last stage when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_req   = r_out;

    // An out-of-range cell always carries a zero byte
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_req.cell_valid) |-> (o_req.fog_byte == 8'd0))
        else $error("invalid cell with nonzero fog byte");

    // A finished request reaches the output register when it is free
    a_last_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last_valid && w_out_free) |=> r_out_valid)
        else $error("finished request lost at output");

    // A stalled input means a result is held and the last stage is full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && w_last_valid))
        else $error("input stalled without cause");

    // A mode write takes effect on the next cycle
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == rfft_pkg::CFG_MODE)) |=>
        (r_fog_mode == $past(i_cfg_data[1:0])))
        else $error("fog mode write not applied");

endmodule

@@ rtl/rfft_dist.sv @@
// Distance pipeline: cell range check, x and z scaling, squares and a
// one-bit-per-stage square root. Uses rfft_pkg.
module rfft_dist #(
    parameter int unsigned MAX_STEPS = rfft_pkg::MAX_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  rfft_pkg::t_in_req     i_req,
    input  logic [15:0]           i_step_length,
    input  logic [8:0]            i_steps_in_use,
    output logic                  o_valid,
    output rfft_pkg::t_dist_req   o_dist
);
    localparam int unsigned LIM_W0 = $clog2(MAX_STEPS + 1);
    localparam int unsigned LIM_W  = (LIM_W0 > 9) ? LIM_W0 : 9;
    localparam int unsigned NSQ    = 25;

    logic [LIM_W-1:0] w_steps, w_lim, w_cx, w_cz;
    logic             w_ok;

    logic        r_v0, r_ok0, r_v1, r_ok1;
    logic [23:0] r_x0, r_z0;
    logic [47:0] r_xx1, r_zz1;

    logic [NSQ:0] r_sv, r_sok;
    logic [48:0]  r_rem [0:NSQ];
    logic [49:0]  r_res [0:NSQ];

    logic [49:0] w_try [0:NSQ-1];
    logic [48:0] n_rem [0:NSQ-1];
    logic [49:0] n_res [0:NSQ-1];

    // Range check against the smaller of the register and the table size
    assign w_steps = LIM_W'(i_steps_in_use);
    assign w_lim   = (w_steps > LIM_W'(MAX_STEPS)) ? LIM_W'(MAX_STEPS) : w_steps;
    assign w_cx    = LIM_W'(i_req.cell_x);
    assign w_cz    = LIM_W'(i_req.cell_z);
    assign w_ok    = (w_cx < w_lim) && (w_cz < w_lim);

    // Square root steps: try one result bit per stage
    always_comb begin
        for (int k = 0; k < NSQ; k++) begin
            w_try[k] = r_res[k] + (50'(1) << (48 - 2 * k));
            if ({1'b0, r_rem[k]} >= w_try[k]) begin
                n_rem[k] = r_rem[k] - w_try[k][48:0];
                n_res[k] = (r_res[k] >> 1) + (50'(1) << (48 - 2 * k));
            end else begin
                n_rem[k] = r_rem[k];
                n_res[k] = r_res[k] >> 1;
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_sv <= '0;
        end else if (i_adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_sv <= {r_sv[NSQ-1:0], r_v1};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ok0    <= w_ok;
            r_x0     <= {16'd0, i_req.cell_x} * {8'd0, i_step_length};
            r_z0     <= {16'd0, i_req.cell_z} * {8'd0, i_step_length};
            r_ok1    <= r_ok0;
            r_xx1    <= 48'(r_x0) * 48'(r_x0);
            r_zz1    <= 48'(r_z0) * 48'(r_z0);
            r_rem[0] <= 49'(r_xx1) + 49'(r_zz1);
            r_res[0] <= '0;
            r_sok    <= {r_sok[NSQ-1:0], r_ok1};
            for (int k = 0; k < NSQ; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_res[k+1] <= n_res[k];
            end
        end
    end

    assign o_valid    = r_sv[NSQ];
    assign o_dist.ok  = r_sok[NSQ];
    assign o_dist.rad = r_res[NSQ][24:0];

endmodule

@@ rtl/rfft_div.sv @@
// Factor classification and the restoring divider for linear and exponent
// quotients. Uses rfft_pkg.
module rfft_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  rfft_pkg::t_dist_req   i_dist,
    input  logic [1:0]            i_fog_mode,
    input  logic [23:0]           i_near,
    input  logic [23:0]           i_far,
    input  logic [15:0]           i_density,
    output logic                  o_valid,
    output rfft_pkg::t_fac_req    o_fac
);
    localparam int unsigned NQ = 21;

    logic           w_below, w_nofog, w_past;
    rfft_pkg::t_cls w_cls;
    logic [24:0]    w_d;
    logic [40:0]    w_prod;
    logic [48:0]    w_num;
    logic [23:0]    w_span;
    logic           w_sat;

    logic           r_v0, r_ok0, r_exp2_0;
    rfft_pkg::t_cls r_cls0;
    logic [48:0]    r_num0;

    logic [NQ:0]    r_dv, r_ok, r_exp2, r_sat;
    rfft_pkg::t_cls r_cls [0:NQ];
    logic [48:0]    r_rem [0:NQ];
    logic [20:0]    r_q   [0:NQ];

    logic [48:0] w_dsh [0:NQ-1];
    logic [48:0] n_rem [0:NQ-1];
    logic [20:0] n_q   [0:NQ-1];

    // Classify the cell and form the dividend
    always_comb begin
        w_below = i_dist.rad < {1'b0, i_near};
        w_nofog = i_far <= i_near;
        w_past  = i_dist.rad >= {1'b0, i_far};
        w_d     = i_dist.rad - {1'b0, i_near};
        w_prod  = 41'(w_d) * 41'(i_density);
        if (w_below) begin
            w_cls = rfft_pkg::CLS_ONE;
        end else if (w_nofog) begin
            w_cls = rfft_pkg::CLS_ZERO;
        end else if (i_fog_mode == rfft_pkg::MODE_LIN) begin
            w_cls = w_past ? rfft_pkg::CLS_ZERO : rfft_pkg::CLS_LIN;
        end else begin
            w_cls = rfft_pkg::CLS_EXP;
        end
        if (i_fog_mode == rfft_pkg::MODE_LIN) begin
            w_num = {9'd0, i_far - i_dist.rad[23:0], 16'd0};
        end else begin
            w_num = {w_prod, 8'd0};
        end
    end

    // Saturate quotients that would overflow 21 bits to the exponent limit
    assign w_span = i_far - i_near;
    assign w_sat  = r_num0 >= 49'({w_span, 21'd0});

    // Divider steps: one quotient bit per stage, most significant first
    always_comb begin
        for (int j = 0; j < NQ; j++) begin
            w_dsh[j] = 49'(w_span) << (NQ - 1 - j);
            if (r_rem[j] >= w_dsh[j]) begin
                n_rem[j] = r_rem[j] - w_dsh[j];
                n_q[j]   = r_q[j] | (21'(1) << (NQ - 1 - j));
            end else begin
                n_rem[j] = r_rem[j];
                n_q[j]   = r_q[j];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_dv <= '0;
        end else if (i_adv) begin
            r_v0 <= i_valid;
            r_dv <= {r_dv[NQ-1:0], r_v0};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ok0    <= i_dist.ok;
            r_cls0   <= w_cls;
            r_exp2_0 <= (i_fog_mode != rfft_pkg::MODE_LIN) &&
                        (i_fog_mode != rfft_pkg::MODE_EXP);
            r_num0   <= w_num;
            r_ok     <= {r_ok[NQ-1:0], r_ok0};
            r_exp2   <= {r_exp2[NQ-1:0], r_exp2_0};
            r_sat    <= {r_sat[NQ-1:0], w_sat};
            r_cls[0] <= r_cls0;
            r_rem[0] <= r_num0;
            r_q[0]   <= '0;
            for (int j = 0; j < NQ; j++) begin
                r_cls[j+1] <= r_cls[j];
                r_rem[j+1] <= n_rem[j];
                r_q[j+1]   <= n_q[j];
            end
        end
    end

    assign o_valid    = r_dv[NQ];
    assign o_fac.ok   = r_ok[NQ];
    assign o_fac.cls  = r_cls[NQ];
    assign o_fac.exp2 = r_exp2[NQ];
    assign o_fac.q    = r_sat[NQ] ? rfft_pkg::T_LIMIT : r_q[NQ];

endmodule

@@ rtl/rfft_exp.sv @@
// Exponential unit: squared exponent, e^(-t/16) series, four squarings and
// the final scaling to a byte. Uses rfft_pkg.
module rfft_exp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  rfft_pkg::t_fac_req    i_fac,
    output logic                  o_valid,
    output rfft_pkg::t_out_req    o_req
);
    localparam int unsigned NT = 14;
    localparam int unsigned NS = 4;

    // Floor of 2^32 / k for k = 1..14
    localparam logic [32:0] RECIP [0:NT-1] = '{
        33'h100000000, 33'h080000000, 33'h055555555, 33'h040000000,
        33'h033333333, 33'h02AAAAAAA, 33'h024924924, 33'h020000000,
        33'h01C71C71C, 33'h019999999, 33'h01745D174, 33'h015555555,
        33'h013B13B13, 33'h012492492
    };

    typedef struct packed {
        logic           ok;
        rfft_pkg::t_cls cls;
        logic           tz;
        logic           tbig;
        logic [16:0]    q;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [31:0] x;
        logic [32:0] term;
        logic [33:0] sum;
        logic [31:0] p;
        logic [31:0] e;
    } t_ser;

    typedef struct packed {
        t_side       side;
        logic [31:0] s;
    } t_sq;

    logic [41:0] w_qq;
    logic [23:0] w_t;

    logic               r_v0;
    rfft_pkg::t_fac_req r_f0;
    logic [23:0]        r_t0;

    logic [NT-1:0] r_va, r_vb;
    logic [NT:0]   r_vc;
    t_ser          r_sa [0:NT-1];
    t_ser          r_sb [0:NT-1];
    t_ser          r_sc [0:NT];
    t_ser          n_st;

    logic [64:0] w_pa [0:NT-1];
    logic [64:0] w_pb [0:NT-1];
    logic [35:0] w_ek [0:NT-1];
    logic [35:0] w_r  [0:NT-1];
    logic [31:0] w_qt [0:NT-1];
    t_ser        n_sa [0:NT-1];
    t_ser        n_sb [0:NT-1];
    t_ser        n_sc [0:NT-1];

    logic [NS:0] r_qv;
    t_sq         r_qs [0:NS];
    logic [63:0] w_pp [0:NS-1];

    t_side               w_fs;
    logic [16:0]         w_fac;
    logic [24:0]         w_scaled;
    logic                r_ov;
    rfft_pkg::t_out_req  r_o;

    // Square the exponent in the squared mode, hold it at the limit
    always_comb begin
        w_qq = 42'(i_fac.q) * 42'(i_fac.q);
        if (!i_fac.exp2) begin
            w_t = 24'(i_fac.q);
        end else if (i_fac.q >= rfft_pkg::T_LIMIT) begin
            w_t = 24'(rfft_pkg::T_LIMIT);
        end else begin
            w_t = w_qq[39:16];
        end
    end

    // Series start: flags for zero and out-of-range exponents
    always_comb begin
        n_st.side.ok   = r_f0.ok;
        n_st.side.cls  = r_f0.cls;
        n_st.side.tz   = (r_t0 == 24'd0);
        n_st.side.tbig = (r_t0 >= 24'(rfft_pkg::T_LIMIT));
        n_st.side.q    = r_f0.q[16:0];
        n_st.x         = n_st.side.tbig ? 32'd0 : {r_t0[19:0], 12'd0};
        n_st.term      = 33'h100000000;
        n_st.sum       = 34'h100000000;
        n_st.p         = '0;
        n_st.e         = '0;
    end

    // Series terms: multiply, reciprocal estimate, then correct and accumulate
    always_comb begin
        for (int k = 0; k < NT; k++) begin
            w_pa[k]   = 65'(r_sc[k].term) * 65'(r_sc[k].x);
            n_sa[k]   = r_sc[k];
            n_sa[k].p = w_pa[k][63:32];

            w_pb[k]   = 65'(r_sa[k].p) * 65'(RECIP[k]);
            n_sb[k]   = r_sa[k];
            n_sb[k].e = w_pb[k][63:32];

            w_ek[k] = 36'(r_sb[k].e) * 36'(k + 1);
            w_r[k]  = 36'(r_sb[k].p) - w_ek[k];
            w_qt[k] = (w_r[k] >= 36'(k + 1)) ? r_sb[k].e + 32'd1 : r_sb[k].e;
            n_sc[k]      = r_sb[k];
            n_sc[k].term = 33'(w_qt[k]);
            if ((k % 2) == 0) begin
                n_sc[k].sum = r_sb[k].sum - 34'(w_qt[k]);
            end else begin
                n_sc[k].sum = r_sb[k].sum + 34'(w_qt[k]);
            end
        end
        for (int j = 0; j < NS; j++) begin
            w_pp[j] = 64'(r_qs[j].s) * 64'(r_qs[j].s);
        end
    end

    // Select the factor and scale it to a byte
    always_comb begin
        w_fs = r_qs[NS].side;
        case (w_fs.cls)
            rfft_pkg::CLS_ONE:  w_fac = 17'h10000;
            rfft_pkg::CLS_ZERO: w_fac = 17'd0;
            rfft_pkg::CLS_LIN:  w_fac = w_fs.q;
            rfft_pkg::CLS_EXP: begin
                if (w_fs.tz) begin
                    w_fac = 17'h10000;
                end else if (w_fs.tbig) begin
                    w_fac = 17'd0;
                end else begin
                    w_fac = {1'b0, r_qs[NS].s[31:16]};
                end
            end
            default: w_fac = 17'd0;
        endcase
        w_scaled = {w_fac, 8'd0} - 25'(w_fac);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_va <= '0;
            r_vb <= '0;
            r_vc <= '0;
            r_qv <= '0;
            r_ov <= 1'b0;
        end else if (i_adv) begin
            r_v0    <= i_valid;
            r_vc[0] <= r_v0;
            for (int k = 0; k < NT; k++) begin
                r_va[k]   <= r_vc[k];
                r_vb[k]   <= r_va[k];
                r_vc[k+1] <= r_vb[k];
            end
            r_qv <= {r_qv[NS-1:0], r_vc[NT]};
            r_ov <= r_qv[NS];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_f0    <= i_fac;
            r_t0    <= w_t;
            r_sc[0] <= n_st;
            for (int k = 0; k < NT; k++) begin
                r_sa[k]   <= n_sa[k];
                r_sb[k]   <= n_sb[k];
                r_sc[k+1] <= n_sc[k];
            end
            r_qs[0].side <= r_sc[NT].side;
            r_qs[0].s    <= r_sc[NT].sum[31:0];
            for (int j = 0; j < NS; j++) begin
                r_qs[j+1].side <= r_qs[j].side;
                r_qs[j+1].s    <= w_pp[j][63:32];
            end
            r_o.cell_valid <= w_fs.ok;
            r_o.fog_byte   <= w_fs.ok ? w_scaled[23:16] : 8'd0;
        end
    end

    assign o_valid = r_ov;
    assign o_req   = r_o;

endmodule

@@ tb/tb_radial_fog_factor_table_core.sv @@
// Self-checking testbench of radial_fog_factor_table_core: directed table, then random cells
// over several register settings, checked against a fog factor predictor. Depends on rfft_pkg.
module tb_radial_fog_factor_table_core;

    localparam logic [1:0] MODE_EXP2  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         WDOG_LIMIT = 3000;
    localparam int         DRAIN_CYC  = 120;
    localparam int         N_PHASE    = 10;
    localparam int         PHASE_ITEMS = 145;

    typedef struct {
        logic [7:0]          cx;
        logic [7:0]          cz;
        bit                  known;
        rfft_pkg::t_out_req  res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    rfft_pkg::t_in_req  i_req = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    rfft_pkg::t_out_req o_req;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    // predictor copy of the registers
    logic [1:0]  fog_mode;
    logic [23:0] near_dist;
    logic [23:0] far_dist;
    logic [15:0] density;
    logic [15:0] step_len;
    logic [8:0]  steps_used;

    rfft_pkg::t_out_req fog_expect_q[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       burst = 1'b0;
    bit       hold_req = 1'b0;

    radial_fog_factor_table_core i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // e^(-t), t in Q.16, result Q1.16
    function automatic logic [63:0] decay(logic [63:0] t);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        if (t == 0) return 64'd65536;
        if (t >= 64'(rfft_pkg::T_LIMIT)) return 64'd0;
        x = t << 12;
        term = 64'd1 << 32;
        sum = 64'd1 << 32;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * x) >> 32) / k;
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        for (int k = 0; k < 4; k++) sum = (sum * sum) >> 32;
        return sum >> 16;
    endfunction

    function automatic rfft_pkg::t_out_req fog_cell(rfft_pkg::t_in_req c);
        rfft_pkg::t_out_req r;
        logic [63:0] lim;
        logic [63:0] x;
        logic [63:0] z;
        logic [63:0] rad;
        logic [63:0] fac;
        logic [63:0] span;
        logic [63:0] t;
        lim = (steps_used > rfft_pkg::MAX_STEPS_DEF) ? 64'(rfft_pkg::MAX_STEPS_DEF)
                                                     : 64'(steps_used);
        r = '0;
        if (c.cell_x >= lim || c.cell_z >= lim) return r;
        x = 64'(c.cell_x) * step_len;
        z = 64'(c.cell_z) * step_len;
        rad = root_floor(x * x + z * z);
        if (rad < near_dist) begin
            fac = 65536;
        end else if (far_dist <= near_dist) begin
            fac = 0;
        end else begin
            span = far_dist - near_dist;
            if (fog_mode == rfft_pkg::MODE_LIN) begin
                fac = (rad >= far_dist) ? 64'd0 : ((64'(far_dist) - rad) << 16) / span;
            end else begin
                t = (((rad - near_dist) * density) << 8) / span;
                if (fog_mode != rfft_pkg::MODE_EXP) begin
                    t = (t >= 64'(rfft_pkg::T_LIMIT)) ? 64'(rfft_pkg::T_LIMIT)
                                                      : (t * t) >> 16;
                end
                fac = decay(t);
            end
        end
        if (fac > 65536) fac = 65536;
        r.fog_byte = 8'((fac * 255) >> 16);
        r.cell_valid = 1'b1;
        return r;
    endfunction

    // write one register and mirror it in the predictor
    task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            rfft_pkg::CFG_MODE:  fog_mode = data[1:0];
            rfft_pkg::CFG_NEAR:  near_dist = data;
            rfft_pkg::CFG_FAR:   far_dist = data;
            rfft_pkg::CFG_DENS:  density = data[15:0];
            rfft_pkg::CFG_STEP:  step_len = data[15:0];
            rfft_pkg::CFG_STEPS: steps_used = data[8:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [1:0] m, logic [23:0] n, logic [23:0] f,
                           logic [15:0] d, logic [15:0] s, logic [8:0] st);
        cfg_write(rfft_pkg::CFG_MODE, 24'(m));
        cfg_write(rfft_pkg::CFG_NEAR, n);
        cfg_write(rfft_pkg::CFG_FAR, f);
        cfg_write(rfft_pkg::CFG_DENS, 24'(d));
        cfg_write(rfft_pkg::CFG_STEP, 24'(s));
        cfg_write(rfft_pkg::CFG_STEPS, 24'(st));
        i_cfg_we <= 1'b0;
    endtask

    // offer one request and queue its expected result once taken
    task automatic send_cell(logic [7:0] cx, logic [7:0] cz, bit known,
                             rfft_pkg::t_out_req res);
        int gap;
        rfft_pkg::t_in_req c;
        c.cell_x = cx;
        c.cell_z = cz;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= c;
        do @(posedge i_clk); while (o_stall);
        fog_expect_q.push_back(known ? res : fog_cell(c));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        wait (fog_expect_q.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // receiver: random stalls, stall-free bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = burst ? 0 : $urandom_range(0, 16);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    // check results against the oldest expectation
    always @(posedge i_clk) begin
        rfft_pkg::t_out_req e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fog_expect_q.size() == 0) begin
                $error("unexpected result fog_byte=%0d cell_valid=%0d",
                       o_req.fog_byte, o_req.cell_valid);
                errors++;
            end else begin
                e = fog_expect_q.pop_front();
                if (o_req.fog_byte !== e.fog_byte) begin
                    $error("fog_byte expected %0d actual %0d", e.fog_byte, o_req.fog_byte);
                    errors++;
                end
                if (o_req.cell_valid !== e.cell_valid) begin
                    $error("cell_valid expected %0d actual %0d",
                           e.cell_valid, o_req.cell_valid);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("radial_fog_factor_table_core test failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        rfft_pkg::t_out_req none;
        logic [1:0]  m;
        logic [23:0] n;
        logic [23:0] f;
        logic [8:0]  st;
        int          lim;
        none = '0;
        rows = '{
            '{8'd0,   8'd0,   1'b1, '{fog_byte: 8'd255, cell_valid: 1'b1}},
            '{8'd255, 8'd255, 1'b0, none},
            '{8'd255, 8'd0,   1'b0, none},
            '{8'd0,   8'd255, 1'b0, none},
            '{8'd1,   8'd1,   1'b0, none},
            '{8'd128, 8'd64,  1'b0, none},
            '{8'hAA,  8'h55,  1'b0, none},
            '{8'h55,  8'hAA,  1'b0, none},
            '{8'd7,   8'd200, 1'b0, none}
        };
        fog_mode = rfft_pkg::MODE_LIN; near_dist = '0; far_dist = rfft_pkg::FAR_RST;
        density = rfft_pkg::DENS_RST; step_len = rfft_pkg::STEP_RST;
        steps_used = rfft_pkg::STEPS_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset settings
        foreach (rows[r]) send_cell(rows[r].cx, rows[r].cz, rows[r].known, rows[r].res);
        drain();

        for (int p = 0; p < N_PHASE; p++) begin
            case (p)
                0: cfg_all(rfft_pkg::MODE_EXP, 24'd0, 24'd5120, 16'd256, 16'd256, 9'd256);
                1: cfg_all(MODE_EXP2, 24'd1000, 24'd20000, 16'd700, 16'd128, 9'd200);
                2: cfg_all(MODE_SPARE, 24'd500, 24'd9000, 16'd300, 16'd256, 9'd100);
                3: cfg_all(rfft_pkg::MODE_LIN, 24'd8000, 24'd4000, 16'd256, 16'd256, 9'd256);
                4: cfg_all(rfft_pkg::MODE_LIN, 24'd0, 24'd3000, 16'd0, 16'd0, 9'd0);
                5: cfg_all(rfft_pkg::MODE_EXP, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF,
                           9'h1FF);
                6: cfg_all(rfft_pkg::MODE_EXP, 24'd0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 9'd256);
                default: begin
                    m = 2'($urandom_range(0, 3));
                    n = 24'($urandom_range(0, 40000));
                    f = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 40000))
                                                   : n + 24'($urandom_range(1, 80000));
                    st = 9'($urandom_range(1, 256));
                    cfg_all(m, n, f, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(1, 1024)), st);
                end
            endcase
            burst = (p % 3 == 0);
            // long hold-off during a gap-free phase so the pipeline fills up
            if (p == 3) hold_req = 1'b1;
            lim = (steps_used == 0) ? 1 : ((steps_used > 256) ? 256 : int'(steps_used));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly cells in range, a few beyond the limit
                if ($urandom_range(0, 7) == 0)
                    send_cell(8'($urandom), 8'($urandom), 1'b0, none);
                else
                    send_cell(8'($urandom_range(0, lim - 1)),
                              8'($urandom_range(0, lim - 1)), 1'b0, none);
            end
            burst = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("radial_fog_factor_table_core test passed");
        end else begin
            $display("radial_fog_factor_table_core test failed");
        end
        $finish;
    end

endmodule
